### rtl/core/spr_pkg.sv
// Shared constants, codes and control types of the spin-rate PI controller.
package spr_pkg;

   localparam int DEF_WINDOW      = 10;
   localparam int DEF_SAMPLE_BITS = 12;

   localparam int GAIN_SCALE     = 10000;
   localparam int SETPOINT_BITS  = 12;
   localparam int GAIN_BITS      = 16;
   localparam int LIMIT_BITS     = 7;
   localparam int BAND_BITS      = 8;
   localparam int CORR_BITS      = 8;
   localparam int INTEG_BITS     = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // divisor width covers any window length up to thirty-one
   localparam int DVR_BITS    = 5;
   // |acc| below (limit+1)*scale, at most 128*10000
   localparam int PI_MAG_BITS = 21;
   localparam int MUL_A_BITS  = GAIN_BITS + 1;
   localparam int MUL_B_BITS  = INTEG_BITS;
   localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
   localparam int ACC_BITS    = PROD_BITS + 1;

   // scale-down by the gain scale as a reciprocal multiply:
   // ceil(2^35 / 10000), exact for any magnitude below 2^21
   localparam int                    RECIP_BITS  = 22;
   localparam int                    RECIP_SHIFT = 35;
   localparam logic [RECIP_BITS-1:0] RECIP_MULT  = 22'd3435974;

   localparam logic [SETPOINT_BITS-1:0] RST_SETPOINT   = 12'd418;
   localparam logic [GAIN_BITS-1:0]     RST_PROP_GAIN  = 16'd20300;
   localparam logic [GAIN_BITS-1:0]     RST_INTEG_GAIN = 16'd10;
   localparam logic [LIMIT_BITS-1:0]    RST_LIMIT      = 7'd10;
   localparam logic [BAND_BITS-1:0]     RST_DEAD_BAND  = 8'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SETPOINT   = 3'd0,
      CSR_PROP_GAIN  = 3'd1,
      CSR_INTEG_GAIN = 3'd2,
      CSR_LIMIT      = 3'd3,
      CSR_DEAD_BAND  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILT_DIV,
      S_ERR,
      S_MUL_P,
      S_MUL_I,
      S_ACC,
      S_CMP,
      S_PI_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic calc_err;
      logic mul_p;
      logic mul_i;
      logic sum_acc;
      logic compare;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_busy;
   } status_type;

endpackage

### rtl/core/spr_divider.sv
// Restoring divider, one quotient bit per cycle, forming the moving-average mean.
module spr_divider #(
   parameter int DIV_BITS = 21
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIV_BITS-1:0]          dividend,
   input  logic [spr_pkg::DVR_BITS-1:0] divisor,
   output logic                         last,
   output logic [DIV_BITS-1:0]          quotient
);
   import spr_pkg::*;

   localparam int CNT_BITS = (DIV_BITS > 1) ? $clog2(DIV_BITS) : 1;

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DVR_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DVR_BITS-1:0] dvr_ff;
   logic [DVR_BITS:0]   shifted;
   logic [DVR_BITS+1:0] diff;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[DIV_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvr_ff};
   assign fits    = !diff[DVR_BITS+1];
   assign last    = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIV_BITS - 1);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVR_BITS-1:0] : shifted[DVR_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvr_ff <= divisor;
      end
   end

endmodule

### rtl/core/spr_datapath.sv
// Filter ring, PI arithmetic, configuration registers and result register.
module spr_datapath #(
   parameter int WINDOW      = spr_pkg::DEF_WINDOW,
   parameter int SAMPLE_BITS = spr_pkg::DEF_SAMPLE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  spr_pkg::cmd_type                   cmd,
   output spr_pkg::status_type                status,
   input  logic [SAMPLE_BITS-1:0]             sample,
   input  logic                               csr_write,
   input  logic [spr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [spr_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                               rsp_take,
   output logic                               rsp_valid,
   output logic [spr_pkg::CORR_BITS-1:0]      rsp_corr,
   output logic [SAMPLE_BITS-1:0]             rsp_filt,
   output logic                               rsp_clamped
);
   import spr_pkg::*;

   localparam int PTR_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;
   localparam int DIV_BITS = SUM_BITS;
   localparam int ERR_BITS = ((SAMPLE_BITS > SETPOINT_BITS) ? SAMPLE_BITS : SETPOINT_BITS) + 1;

   // configuration
   logic [SETPOINT_BITS-1:0] setpoint_ff, setpoint_in;
   logic [GAIN_BITS-1:0]     prop_ff, prop_in;
   logic [GAIN_BITS-1:0]     integ_ff, integ_in;
   logic [LIMIT_BITS-1:0]    limit_ff, limit_in;
   logic [BAND_BITS-1:0]     band_ff, band_in;

   // moving-average filter
   logic [SAMPLE_BITS-1:0] ring [WINDOW];
   logic [SAMPLE_BITS-1:0] ring_rd_ff;
   logic [PTR_BITS-1:0]    ptr_ff, ptr_in, ptr_next;
   logic                   full_ff, full_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in, sum_add;
   logic                   sub_ff, sub_in;
   logic                   warm;

   // PI
   logic signed [ERR_BITS-1:0]   err_ff, err_in, err_raw;
   logic [ERR_BITS-1:0]          err_mag;
   logic [SAMPLE_BITS-1:0]       filt_ff, filt_in;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in, pprod_ff;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in, acc_mag, thr_s;
   logic [PI_MAG_BITS-1:0]       thr_ff, thr_in;
   logic [PI_MAG_BITS-1:0]       mag_ff;
   logic [PI_MAG_BITS+RECIP_BITS-1:0] scaled_ff;
   logic [CORR_BITS-1:0]         lim_p1;
   logic                         pos_ff, negc_ff, sign_ff;
   logic signed [INTEG_BITS-1:0] integral_ff, integral_in;
   logic signed [INTEG_BITS:0]   integ_sum;

   // divider
   logic                div_start, div_last;
   logic [DIV_BITS-1:0] div_dividend, div_quo;
   logic [DVR_BITS-1:0] div_divisor;

   // result
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CORR_BITS-1:0]   corr_ff, corr_in, q_corr, lim_corr;
   logic [SAMPLE_BITS-1:0] rfilt_ff;
   logic                   clamp_ff, clamp_in;

   // ---------------- configuration writes
   always_comb begin
      setpoint_in = setpoint_ff;
      prop_in     = prop_ff;
      integ_in    = integ_ff;
      limit_in    = limit_ff;
      band_in     = band_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SETPOINT:   setpoint_in = csr_data[SETPOINT_BITS-1:0];
            CSR_PROP_GAIN:  prop_in     = csr_data[GAIN_BITS-1:0];
            CSR_INTEG_GAIN: integ_in    = csr_data[GAIN_BITS-1:0];
            CSR_LIMIT:      limit_in    = csr_data[LIMIT_BITS-1:0];
            CSR_DEAD_BAND:  band_in     = csr_data[BAND_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- filter
   assign warm     = !full_ff && (ptr_ff != PTR_BITS'(WINDOW - 1));
   assign ptr_next = (ptr_ff == PTR_BITS'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
   assign sum_add  = sum_ff + SUM_BITS'(sample);

   always_comb begin
      ptr_in  = ptr_ff;
      full_in = full_ff;
      sum_in  = sum_ff;
      sub_in  = 1'b0;
      if (cmd.load) begin
         sum_in = sum_add;
         if (warm) begin
            ptr_in = ptr_ff + 1'b1;
         end else begin
            ptr_in  = ptr_next;
            full_in = 1'b1;
            sub_in  = 1'b1;
         end
      end else if (sub_ff) begin
         // drop the oldest sample once the mean has been taken
         sum_in = sum_ff - SUM_BITS'(ring_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ring[ptr_ff] <= sample;
         ring_rd_ff   <= ring[ptr_next];
      end
   end

   // ---------------- error and deadband
   assign err_raw = $signed(ERR_BITS'(div_quo[SAMPLE_BITS-1:0]))
                    - $signed(ERR_BITS'(setpoint_ff));
   assign err_mag = err_raw[ERR_BITS-1] ? ERR_BITS'(-err_raw) : ERR_BITS'(err_raw);

   always_comb begin
      filt_in = filt_ff;
      err_in  = err_ff;
      if (cmd.calc_err) begin
         filt_in = div_quo[SAMPLE_BITS-1:0];
         err_in  = (err_mag <= ERR_BITS'(band_ff)) ? '0 : err_raw;
      end
   end

   // ---------------- shared multiplier
   assign mul_a   = cmd.mul_p ? $signed({1'b0, prop_ff}) : $signed({1'b0, integ_ff});
   assign mul_b   = cmd.mul_p ? MUL_B_BITS'(err_ff) : integral_ff;
   assign prod_in = (cmd.mul_p || cmd.mul_i) ? mul_a * mul_b : prod_ff;

   assign acc_in = cmd.sum_acc ? ACC_BITS'(pprod_ff) + ACC_BITS'(prod_ff) : acc_ff;
   assign lim_p1 = {1'b0, limit_ff} + 1'b1;
   assign thr_in = cmd.sum_acc ? PI_MAG_BITS'(PI_MAG_BITS'(lim_p1) * PI_MAG_BITS'(GAIN_SCALE))
                               : thr_ff;

   // ---------------- clamp test and magnitude for the scale-down
   assign thr_s   = $signed(ACC_BITS'(thr_ff));
   assign acc_mag = acc_ff[ACC_BITS-1] ? -acc_ff : acc_ff;

   // ---------------- divider for the mean
   assign div_start    = cmd.load;
   assign div_dividend = sum_add;
   assign div_divisor  = warm ? DVR_BITS'(ptr_ff) + 1'b1 : DVR_BITS'(WINDOW);

   spr_divider #(
      .DIV_BITS (DIV_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .last     (div_last),
      .quotient (div_quo)
   );

   // ---------------- result and integral
   assign q_corr   = scaled_ff[RECIP_SHIFT +: CORR_BITS];
   assign lim_corr = {1'b0, limit_ff};
   assign integ_sum = INTEG_BITS'(integral_ff) + (INTEG_BITS + 1)'(err_ff);

   always_comb begin
      if (pos_ff) begin
         corr_in = lim_corr;
      end else if (negc_ff) begin
         corr_in = -lim_corr;
      end else if (sign_ff) begin
         corr_in = -q_corr;
      end else begin
         corr_in = q_corr;
      end
      clamp_in     = pos_ff || negc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      integral_in  = integral_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         if (!clamp_in) begin
            if (integ_sum[INTEG_BITS] != integ_sum[INTEG_BITS-1]) begin
               integral_in = integ_sum[INTEG_BITS] ? {1'b1, {(INTEG_BITS-1){1'b0}}}
                                                   : {1'b0, {(INTEG_BITS-1){1'b1}}};
            end else begin
               integral_in = integ_sum[INTEG_BITS-1:0];
            end
         end
      end
   end

   // ---------------- registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= RST_SETPOINT;
         prop_ff      <= RST_PROP_GAIN;
         integ_ff     <= RST_INTEG_GAIN;
         limit_ff     <= RST_LIMIT;
         band_ff      <= RST_DEAD_BAND;
         ptr_ff       <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         sub_ff       <= 1'b0;
         integral_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         setpoint_ff  <= setpoint_in;
         prop_ff      <= prop_in;
         integ_ff     <= integ_in;
         limit_ff     <= limit_in;
         band_ff      <= band_in;
         ptr_ff       <= ptr_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         sub_ff       <= sub_in;
         integral_ff  <= integral_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- payload registers
   always_ff @(posedge clock) begin
      filt_ff <= filt_in;
      err_ff  <= err_in;
      prod_ff <= prod_in;
      if (cmd.mul_i) begin
         pprod_ff <= prod_ff;
      end
      acc_ff <= acc_in;
      thr_ff <= thr_in;
      if (cmd.compare) begin
         pos_ff  <= acc_ff >= thr_s;
         negc_ff <= acc_ff <= -thr_s;
         sign_ff <= acc_ff[ACC_BITS-1];
         mag_ff  <= acc_mag[PI_MAG_BITS-1:0];
      end
      // divide the magnitude by the gain scale
      scaled_ff <= mag_ff * RECIP_MULT;
      if (cmd.publish) begin
         corr_ff  <= corr_in;
         rfilt_ff <= filt_ff;
         clamp_ff <= clamp_in;
      end
   end

   assign status.div_last = div_last;
   assign status.out_busy = rsp_valid_ff && !rsp_take;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_corr    = corr_ff;
   assign rsp_filt    = rfilt_ff;
   assign rsp_clamped = clamp_ff;

endmodule

### rtl/core/spr_control.sv
// Sequencer that steps one sample through filter, PI and result stages.
module spr_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  spr_pkg::status_type status,
   output spr_pkg::cmd_type    cmd
);
   import spr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_FILT_DIV;
            end
         end
         S_FILT_DIV: begin
            if (status.div_last) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            cmd.calc_err = 1'b1;
            state_in     = S_MUL_P;
         end
         S_MUL_P: begin
            cmd.mul_p = 1'b1;
            state_in  = S_MUL_I;
         end
         S_MUL_I: begin
            cmd.mul_i = 1'b1;
            state_in  = S_ACC;
         end
         S_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in    = S_CMP;
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_PI_DIV;
         end
         S_PI_DIV: begin
            // wait state while the reciprocal product is registered
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (!status.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/spin_rate_pi_controller.sv
// Spin-rate PI controller: top level joining the sequencer and the datapath.
//
// Takes one raw gyro yaw-rate item on req_, smooths it with a WINDOW-sample
// moving average (the mean of the samples so far during warm-up), forms the
// error against rate_setpoint with a dead band, and returns one rsp_ item per
// input: the PI correction (kp*err + ki*integral)/10000, truncated toward zero
// and clamped to +-output_limit, with the filtered rate and a clamp flag. The
// integral only takes up the error on unclamped steps and saturates at the
// 32-bit signed range. Each item passes through the restoring divider, one
// quotient bit per cycle, which forms the mean over a sample count that
// grows during warm-up from a DIV_BITS-bit sum (SAMPLE_BITS plus the ring
// pointer width, 16 at the default sizes); a new item is only accepted
// once the previous one is published. The scale-down by 10000 is a
// registered reciprocal multiplication. A new item may be accepted
// while the previous result still waits on rsp_; the result register only
// stalls the sequencer when a second result is ready before the first is
// taken. Configuration writes on csr_ are always taken at once and must only
// be issued while the block is idle.
module spin_rate_pi_controller #(
   parameter int WINDOW      = spr_pkg::DEF_WINDOW,
   parameter int SAMPLE_BITS = spr_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: gyro_sample
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,
   // rsp_tdata: spin_correction, filtered_rate, clamped
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_BITS+spr_pkg::CORR_BITS+1+7)/8)*8-1:0] rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [spr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [spr_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import spr_pkg::*;

   localparam int RSP_USED_BITS = CORR_BITS + SAMPLE_BITS + 1;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;

   cmd_type                cmd;
   status_type             status;
   logic                   rsp_valid;
   logic [CORR_BITS-1:0]   rsp_corr;
   logic [SAMPLE_BITS-1:0] rsp_filt;
   logic                   rsp_clamped;

   // configuration writes never stall
   assign csr_ready = 1'b1;

   spr_control u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   spr_datapath #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .sample      (req_tdata[SAMPLE_BITS-1:0]),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_take    (rsp_tready),
      .rsp_valid   (rsp_valid),
      .rsp_corr    (rsp_corr),
      .rsp_filt    (rsp_filt),
      .rsp_clamped (rsp_clamped)
   );

   // pack the result item, lowest field first, zero-filled to whole bytes
   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_clamped, rsp_filt, rsp_corr});

endmodule

### rtl/core/spr_checker.sv
// Port-level checks of the spin-rate PI controller, bound to the top level.
module spr_checker #(
   parameter int RSP_DATA_BITS = 24
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     csr_ready
);
   import spr_pkg::*;

   // a result held back keeps its valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   // a result held back keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // one item in work at a time: the input closes right after an acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while one is in work");

   // the clamp never lets the correction reach the most negative code
   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[CORR_BITS-1:0] != {1'b1, {(CORR_BITS-1){1'b0}}})
      else $error("correction outside the symmetric range");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port stalled");

endmodule

bind spin_rate_pi_controller spr_checker #(
   .RSP_DATA_BITS (RSP_DATA_BITS)
) u_spr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
